FILE: rtl/im2col_pkg.sv
// Shared types and constants of the im2col patch extractor.
`default_nettype none

package im2col_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 3;

   localparam int STORE_ADDR_W = 12;
   localparam int PIXEL_W      = 32;
   localparam int CHANNEL_W    = 8;
   localparam int OUT_POS_W    = 7;
   localparam int COL_VALUE_W  = 32;
   localparam int TAP_W        = 6;

   localparam int IMG_DIM_W = 7;
   localparam int KER_DIM_W = 4;
   localparam int PAD_W     = 3;
   localparam int STEP_W    = 4;

   // window position math: 13-bit signed rows/cols, 25-bit signed addresses
   localparam int POS_W  = 13;
   localparam int CALC_W = 25;
   localparam int PROD_W = OUT_POS_W + STEP_W;
   localparam int CHH_W  = CHANNEL_W + IMG_DIM_W;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd7;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_EXTRACT = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [IMG_DIM_W-1:0] image_height;
      logic [IMG_DIM_W-1:0] image_width;
      logic [KER_DIM_W-1:0] kernel_height;
      logic [KER_DIM_W-1:0] kernel_width;
      logic [PAD_W-1:0]     pad_rows;
      logic [PAD_W-1:0]     pad_cols;
      logic [STEP_W-1:0]    stride_rows;
      logic [STEP_W-1:0]    stride_cols;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_height:  7'd8,
      image_width:   7'd8,
      kernel_height: 4'd3,
      kernel_width:  4'd3,
      pad_rows:      3'd0,
      pad_cols:      3'd0,
      stride_rows:   4'd1,
      stride_cols:   4'd1
   };

   typedef struct packed {
      logic load;    // write the accepted word into the store
      logic start;   // latch an extract word, first products
      logic setup;   // form the row base address, clear tap counters
      logic issue;   // read one tap into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_tap;
      logic empty_kernel;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/im2col_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module im2col_regs
   import im2col_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_IMAGE_HEIGHT:  cfg_in.image_height  = csr_pwdata[IMG_DIM_W-1:0];
            REG_IMAGE_WIDTH:   cfg_in.image_width   = csr_pwdata[IMG_DIM_W-1:0];
            REG_KERNEL_HEIGHT: cfg_in.kernel_height = csr_pwdata[KER_DIM_W-1:0];
            REG_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_pwdata[KER_DIM_W-1:0];
            REG_PAD_ROWS:      cfg_in.pad_rows      = csr_pwdata[PAD_W-1:0];
            REG_PAD_COLS:      cfg_in.pad_cols      = csr_pwdata[PAD_W-1:0];
            REG_STRIDE_ROWS:   cfg_in.stride_rows   = csr_pwdata[STEP_W-1:0];
            REG_STRIDE_COLS:   cfg_in.stride_cols   = csr_pwdata[STEP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_KERNEL_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.kernel_height);
         REG_KERNEL_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.kernel_width);
         REG_PAD_ROWS:      csr_prdata = CSR_DATA_W'(cfg_ff.pad_rows);
         REG_PAD_COLS:      csr_prdata = CSR_DATA_W'(cfg_ff.pad_cols);
         REG_STRIDE_ROWS:   csr_prdata = CSR_DATA_W'(cfg_ff.stride_rows);
         REG_STRIDE_COLS:   csr_prdata = CSR_DATA_W'(cfg_ff.stride_cols);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/im2col_ctrl.sv
// Sequencer: accepts words, steps setup and the tap walk.
`default_nettype none

module im2col_ctrl
   import im2col_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_opcode,
   output logic      req_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd       = '0;
      cmd.load  = accept && (req_opcode == OP_LOAD);
      cmd.start = accept && (req_opcode == OP_EXTRACT);
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.empty_kernel ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = stat.out_free;
            if (cmd.issue && stat.last_tap) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && stat.last_tap |=> state_ff == ST_IDLE)
      else $error("walk did not end after last tap");

endmodule

`default_nettype wire

FILE: rtl/im2col_dpath.sv
// Datapath: image store, window address math, tap counters, output register.
`default_nettype none

module im2col_dpath
   import im2col_pkg::*;
#(
   parameter int STORE_DEPTH   = 4096,
   parameter int DATA_WIDTH    = 32,
   parameter int MAX_KERNEL    = 8,
   parameter int DILATION_ROWS = 1,
   parameter int DILATION_COLS = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  cfg_type                      cfg,
   input  cmd_type                      cmd,
   output status_type                   stat,
   input  wire logic [STORE_ADDR_W-1:0] req_store_address,
   input  wire logic [PIXEL_W-1:0]      req_pixel_word,
   input  wire logic [CHANNEL_W-1:0]    req_channel,
   input  wire logic [OUT_POS_W-1:0]    req_out_row,
   input  wire logic [OUT_POS_W-1:0]    req_out_col,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [COL_VALUE_W-1:0]       rsp_column_value,
   output logic [TAP_W-1:0]             rsp_tap_index,
   output logic                         rsp_is_padding,
   output logic                         rsp_out_of_store,
   output logic                         rsp_last
);

   localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int KCNT_W = $clog2(MAX_KERNEL + 1);

   logic [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];

   logic signed [POS_W-1:0]  row0_ff, row0_in, col0_ff, col0_in;
   logic [CHH_W-1:0]         chh_ff, chh_in;
   logic signed [CALC_W-1:0] rowbase_ff, rowbase_in;
   logic signed [POS_W-1:0]  row_cur_ff, row_cur_in, col_cur_ff, col_cur_in;
   logic [KCNT_W-1:0]        i_ff, i_in, j_ff, j_in;
   logic [TAP_W-1:0]         tap_cnt_ff, tap_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]    rd_data_ff;
   logic [TAP_W-1:0]         tap_ff;
   logic                     pad_ff, over_ff, last_ff;

   logic [PROD_W-1:0]        prod_r, prod_c;
   logic [KCNT_W-1:0]        kh_eff, kw_eff;
   logic                     row_end;
   logic signed [CALC_W-1:0] row_sum, row_step, tap_addr;
   logic                     tap_pad, tap_over, load_en;

   assign kh_eff = (cfg.kernel_height > MAX_KERNEL) ? KCNT_W'(MAX_KERNEL)
                                                    : KCNT_W'(cfg.kernel_height);
   assign kw_eff = (cfg.kernel_width > MAX_KERNEL) ? KCNT_W'(MAX_KERNEL)
                                                   : KCNT_W'(cfg.kernel_width);

   assign prod_r  = req_out_row * cfg.stride_rows;
   assign prod_c  = req_out_col * cfg.stride_cols;
   assign row0_in = $signed(POS_W'(prod_r)) - $signed(POS_W'(cfg.pad_rows));
   assign col0_in = $signed(POS_W'(prod_c)) - $signed(POS_W'(cfg.pad_cols));
   assign chh_in  = req_channel * cfg.image_height;

   assign row_sum  = $signed(CALC_W'(chh_ff)) + CALC_W'(row0_ff);
   assign row_step = $signed(CALC_W'(cfg.image_width)) * $signed(CALC_W'(DILATION_ROWS));

   // per-tap checks off the running row/column registers
   assign row_end  = (j_ff == KCNT_W'(kw_eff - 1'b1));
   assign tap_pad  = row_cur_ff[POS_W-1] || col_cur_ff[POS_W-1]
                  || (row_cur_ff >= $signed(POS_W'(cfg.image_height)))
                  || (col_cur_ff >= $signed(POS_W'(cfg.image_width)));
   assign tap_addr = rowbase_ff + CALC_W'(col_cur_ff);
   assign tap_over = !tap_pad && (tap_addr >= $signed(CALC_W'(STORE_DEPTH)));
   assign load_en  = cmd.load && (32'(req_store_address) < STORE_DEPTH);

   assign stat.out_free     = !rsp_valid_ff || rsp_tready;
   assign stat.last_tap     = row_end && (i_ff == KCNT_W'(kh_eff - 1'b1));
   assign stat.empty_kernel = (kh_eff == '0) || (kw_eff == '0);

   always_comb begin
      rowbase_in = rowbase_ff;
      row_cur_in = row_cur_ff;
      col_cur_in = col_cur_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      tap_cnt_in = tap_cnt_ff;
      if (cmd.setup) begin
         rowbase_in = row_sum * $signed(CALC_W'(cfg.image_width));
         row_cur_in = row0_ff;
         col_cur_in = col0_ff;
         i_in       = '0;
         j_in       = '0;
         tap_cnt_in = '0;
      end else if (cmd.issue) begin
         tap_cnt_in = tap_cnt_ff + 1'b1;
         if (row_end) begin
            j_in       = '0;
            i_in       = i_ff + 1'b1;
            col_cur_in = col0_ff;
            row_cur_in = row_cur_ff + POS_W'(DILATION_ROWS);
            rowbase_in = rowbase_ff + row_step;
         end else begin
            j_in       = j_ff + 1'b1;
            col_cur_in = col_cur_ff + POS_W'(DILATION_COLS);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row0_ff <= row0_in;
         col0_ff <= col0_in;
         chh_ff  <= chh_in;
      end
      rowbase_ff <= rowbase_in;
      row_cur_ff <= row_cur_in;
      col_cur_ff <= col_cur_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      tap_cnt_ff <= tap_cnt_in;
      if (cmd.issue) begin
         tap_ff  <= tap_cnt_ff;
         pad_ff  <= tap_pad;
         over_ff <= tap_over;
         last_ff <= stat.last_tap;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         store_mem[AW'(req_store_address)] <= DATA_WIDTH'(req_pixel_word);
      end
      if (cmd.issue) begin
         rd_data_ff <= store_mem[AW'(tap_addr)];
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_column_value = (pad_ff || over_ff) ? '0 : COL_VALUE_W'(rd_data_ff);
   assign rsp_tap_index    = tap_ff;
   assign rsp_is_padding   = pad_ff;
   assign rsp_out_of_store = over_ff;
   assign rsp_last         = last_ff;

   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> rsp_valid_ff && (rsp_last == $past(stat.last_tap)))
      else $error("issued tap not in output register");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pad_ff && over_ff))
      else $error("padding and store overrun both set");

   a_setup_clears_taps: assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> (tap_cnt_ff == '0) && (i_ff == '0) && (j_ff == '0))
      else $error("tap counters not cleared at setup");

endmodule

`default_nettype wire

FILE: rtl/im2col_patch_extract_core.sv
// Top level of the im2col patch extractor: channels, registers, sequencer, datapath.
//
// req channel: one word per item. tuser is the opcode (load or extract).
// A load word writes pixel_word into the image store at store_address in the
// accept cycle and gives no result; addresses past the store are dropped.
// An extract word walks the kernel window rows first and returns one rsp word
// per tap: the stored pixel, or zero with is_padding when the tap is outside
// the image, or zero with out_of_store when the address passes the store.
// tlast marks the final tap of the window.
// Sequence: for an extract, the accept cycle forms the window corner, the
// setup state forms the row base address, then the single store read port
// delivers one tap per cycle while the rsp side is ready. Words are taken
// only while idle, so a load can be taken while the last result still waits.
// A stalled rsp side holds the output register and pauses the tap walk.
// Reset clears the channels and loads the register defaults (8x8 image, 3x3
// kernel, no padding, unit stride); the image store is not cleared.
// The user writes registers through the csr port only while idle; not enforced.
`default_nettype none

module im2col_patch_extract_core
   import im2col_pkg::*;
#(
   parameter int STORE_DEPTH   = 4096,
   parameter int DATA_WIDTH    = 32,
   parameter int MAX_KERNEL    = 8,
   parameter int DILATION_ROWS = 1,
   parameter int DILATION_COLS = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [11:0] store_address, [43:12] pixel_word, [51:44] channel,
   // [58:52] out_row, [65:59] out_col, [71:66] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] column_value, [37:32] tap_index, [39:38] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] is_padding, [1] out_of_store
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   cfg_type                  cfg;
   cmd_type                  cmd;
   status_type               stat;
   logic [COL_VALUE_W-1:0]   column_value;
   logic [TAP_W-1:0]         tap_index;
   logic                     is_padding;
   logic                     out_of_store;

   im2col_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   im2col_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   im2col_dpath #(
      .STORE_DEPTH   (STORE_DEPTH),
      .DATA_WIDTH    (DATA_WIDTH),
      .MAX_KERNEL    (MAX_KERNEL),
      .DILATION_ROWS (DILATION_ROWS),
      .DILATION_COLS (DILATION_COLS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .stat              (stat),
      .req_store_address (req_tdata[11:0]),
      .req_pixel_word    (req_tdata[43:12]),
      .req_channel       (req_tdata[51:44]),
      .req_out_row       (req_tdata[58:52]),
      .req_out_col       (req_tdata[65:59]),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_column_value  (column_value),
      .rsp_tap_index     (tap_index),
      .rsp_is_padding    (is_padding),
      .rsp_out_of_store  (out_of_store),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, tap_index, column_value};
   assign rsp_tuser = {out_of_store, is_padding};

endmodule

`default_nettype wire
